>>> rtl/oms_pkg.sv
// ----------------------------------------------------------------------------
// oms_pkg: shared types and constants of the outlier median smoother
// Request payload structs, register indexes and register reset values.
// ----------------------------------------------------------------------------
package oms_pkg;

  // sample word width, two's complement Q5.10
  localparam int SAMPLE_BITS = 16;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_ADDR_W-1:0] REG_HALF_WINDOW = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PULL_OFFSET = 2'd2;

  localparam logic [4:0]  HALF_WINDOW_RST = 5'd2;
  localparam logic [14:0] THRESHOLD_RST   = 15'd2048;
  localparam logic [14:0] PULL_OFFSET_RST = 15'd1024;

  // input request
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          segment_last;
  } in_item_t;

  // result request
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          was_outlier;
    logic                          run_last;
  } out_item_t;

endpackage

>>> rtl/outlier_median_smoother_core.sv
// A window holds at most 2k+1 samples (k = effective half window). A new
//   request is taken only in idle, after every result that the previous one
//   releases has been emitted, so a result port stall holds input back.
//   One store read port serves all scans.
// Reset: synchronous, active low; clears window bookkeeping and the result
//   valid, loads register defaults; the sample store itself is not cleared.
// ----------------------------------------------------------------------------
// outlier_median_smoother_core: outlier smoothing over a sliding window
// Keeps the current segment in a circular store and, for each centered
// sample, scans its neighbors and, when it is an outlier, ranks the window to
// find the median, all through one sequencer and one store read port.
// ----------------------------------------------------------------------------
module outlier_median_smoother_core #(
  parameter int MAX_HALF_WINDOW = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  oms_pkg::in_item_t                 in_data,
  // result requests
  output logic                              out_valid,
  input  logic                              out_ready,
  output oms_pkg::out_item_t                out_data,
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [oms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [oms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int SB    = oms_pkg::SAMPLE_BITS;
  localparam int EW    = ((SB > 15) ? SB : 15) + 2;

  localparam logic signed [EW-1:0] SMP_MAX = (EW'(1) <<< (SB - 1)) - EW'(1);
  localparam logic signed [EW-1:0] SMP_MIN = -(EW'(1) <<< (SB - 1));

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_PLAN   = 13'b0000000000010,
    S_CENTER = 13'b0000000000100,
    S_XWAIT  = 13'b0000000001000,
    S_NBR    = 13'b0000000010000,
    S_DECIDE = 13'b0000000100000,
    S_CAND   = 13'b0000001000000,
    S_CANDW  = 13'b0000010000000,
    S_INNER  = 13'b0000100000000,
    S_RANK   = 13'b0001000000000,
    S_MEDFIN = 13'b0010000000000,
    S_EMIT   = 13'b0100000000000,
    S_FINISH = 13'b1000000000000
  } state_t;

  // circular index: (a + b) mod DEPTH for a, b below DEPTH
  function automatic logic [CW-1:0] wrap_idx(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[CW-1:0];
  endfunction

  // configuration registers
  logic [4:0]  cfg_half_window_r;
  logic [14:0] cfg_threshold_r;
  logic [14:0] cfg_pull_offset_r;

  // control registers
  state_t          state_r, state_nxt;
  logic [CW-1:0]   base_r, base_nxt;
  logic [CW-1:0]   filled_r, filled_nxt;
  logic [CW-1:0]   pending_r, pending_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   e_r, e_nxt;
  logic            last_r, last_nxt;
  logic [CW-1:0]   lo_r, lo_nxt;
  logic [CW-1:0]   hi_r, hi_nxt;
  logic [CW-1:0]   scan_j_r, scan_j_nxt;
  logic            iss_r, iss_nxt;
  logic            dv_r, dv_nxt;
  logic [CW-1:0]   jd_r, jd_nxt;
  logic            any_r, any_nxt;
  logic            near_r, near_nxt;
  logic            up_r, up_nxt;
  logic            down_r, down_nxt;
  logic [CW-1:0]   cand_r, cand_nxt;
  logic [CW-1:0]   lt_r, lt_nxt;
  logic [CW-1:0]   le_r, le_nxt;
  logic [CW-1:0]   rlo_r, rlo_nxt;
  logic [CW-1:0]   rhi_r, rhi_nxt;
  logic            out_valid_r, out_valid_nxt;

  // payload registers
  logic signed [SB-1:0] x_r, x_nxt;
  logic signed [SB-1:0] cv_r, cv_nxt;
  logic signed [SB-1:0] tlo_r, tlo_nxt;
  logic signed [SB-1:0] thi_r, thi_nxt;
  logic signed [SB-1:0] res_r, res_nxt;
  logic                 repl_r, repl_nxt;
  oms_pkg::out_item_t   out_data_r, out_data_nxt;

  // store ports
  logic          rd_en;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] rd_phys;
  logic [SB-1:0] rd_data;
  logic          wr_en;
  logic [CW-1:0] wr_phys;

  // admission bookkeeping: drop the oldest entry when the store is full
  logic          full;
  logic [CW-1:0] base_adj;
  logic [CW-1:0] filled_adj;
  logic [CW-1:0] pend_adj;
  logic [CW-1:0] k_eff;

  assign full       = (filled_r == CW'(DEPTH));
  assign base_adj   = full ? wrap_idx(base_r, CW'(1)) : base_r;
  assign filled_adj = full ? CW'(DEPTH - 1) : filled_r;
  assign pend_adj   = (full && (pending_r != '0)) ? pending_r - CW'(1) : pending_r;
  assign wr_phys    = wrap_idx(base_adj, filled_adj);
  assign wr_en      = in_valid && in_ready;
  assign rd_phys    = wrap_idx(base_r, rd_idx);

  // effective half window, clipped to the store size
  assign k_eff = ({3'b000, cfg_half_window_r} > 8'(MAX_HALF_WINDOW))
               ? CW'(MAX_HALF_WINDOW) : CW'(cfg_half_window_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  oms_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_phys[IW-1:0]),
    .wr_data (in_data.sample),
    .rd_en   (rd_en),
    .rd_addr (rd_phys[IW-1:0]),
    .rd_data (rd_data)
  );

  // datapath helpers
  logic signed [SB-1:0] sv;
  logic signed [EW-1:0] diff;
  logic signed [EW-1:0] thr_x;
  logic                 is_near;
  logic [CW:0]          cpk;
  logic [CW-1:0]        fm1;
  logic [CW-1:0]        win_n;
  logic signed [SB:0]   msum;
  logic signed [SB:0]   med;
  logic signed [EW-1:0] pulled;
  logic signed [EW-1:0] clamped;
  logic                 out_free;
  logic                 is_outlier;

  assign sv       = $signed(rd_data);
  assign diff     = EW'(x_r) - EW'(sv);
  assign thr_x    = $signed({{(EW-15){1'b0}}, cfg_threshold_r});
  assign is_near  = (diff <= thr_x) && (diff >= -thr_x);
  assign cpk      = {1'b0, pending_r} + {1'b0, k_r};
  assign fm1      = filled_r - CW'(1);
  assign win_n    = hi_r - lo_r + CW'(1);
  assign msum     = {tlo_r[SB-1], tlo_r} + {thi_r[SB-1], thi_r};
  assign med      = msum >>> 1;
  assign pulled   = down_r ? (EW'(med) + $signed({{(EW-15){1'b0}}, cfg_pull_offset_r}))
                           : (EW'(med) - $signed({{(EW-15){1'b0}}, cfg_pull_offset_r}));
  assign clamped  = (pulled > SMP_MAX) ? SMP_MAX : ((pulled < SMP_MIN) ? SMP_MIN : pulled);
  assign out_free = !out_valid_r || out_ready;
  assign is_outlier = any_r && !near_r && !(up_r && down_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    filled_nxt    = filled_r;
    pending_nxt   = pending_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    scan_j_nxt    = scan_j_r;
    iss_nxt       = iss_r;
    dv_nxt        = dv_r;
    jd_nxt        = jd_r;
    any_nxt       = any_r;
    near_nxt      = near_r;
    up_nxt        = up_r;
    down_nxt      = down_r;
    cand_nxt      = cand_r;
    lt_nxt        = lt_r;
    le_nxt        = le_r;
    rlo_nxt       = rlo_r;
    rhi_nxt       = rhi_r;
    x_nxt         = x_r;
    cv_nxt        = cv_r;
    tlo_nxt       = tlo_r;
    thi_nxt       = thi_r;
    res_nxt       = res_r;
    repl_nxt      = repl_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    rd_idx        = scan_j_r;

    // shared window scan: one store read issued per cycle, data in the next cycle
    if ((state_r == S_NBR) || (state_r == S_INNER)) begin
      if (iss_r) begin
        rd_en      = 1'b1;
        rd_idx     = scan_j_r;
        dv_nxt     = 1'b1;
        jd_nxt     = scan_j_r;
        if (scan_j_r == hi_r) begin
          iss_nxt = 1'b0;
        end else begin
          scan_j_nxt = scan_j_r + CW'(1);
        end
      end else begin
        dv_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          base_nxt    = base_adj;
          filled_nxt  = filled_adj + CW'(1);
          pending_nxt = pend_adj;
          last_nxt    = in_data.segment_last;
          state_nxt   = S_PLAN;
        end
      end

      // find the last center this request releases
      S_PLAN: begin
        k_nxt = k_eff;
        if (last_r) begin
          e_nxt     = fm1;
          state_nxt = S_CENTER;
        end else if ({1'b0, filled_r} >= ({1'b0, pending_r} + {1'b0, k_eff} + (CW+1)'(1))) begin
          e_nxt     = fm1 - k_eff;
          state_nxt = S_CENTER;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      // window bounds, clipped at the segment edges; fetch the center
      S_CENTER: begin
        lo_nxt     = (pending_r > k_r) ? pending_r - k_r : '0;
        hi_nxt     = (cpk > {1'b0, fm1}) ? fm1 : cpk[CW-1:0];
        rd_en      = 1'b1;
        rd_idx     = pending_r;
        scan_j_nxt = (pending_r > k_r) ? pending_r - k_r : '0;
        iss_nxt    = 1'b1;
        dv_nxt     = 1'b0;
        any_nxt    = 1'b0;
        near_nxt   = 1'b0;
        up_nxt     = 1'b0;
        down_nxt   = 1'b0;
        state_nxt  = S_XWAIT;
      end

      S_XWAIT: begin
        x_nxt     = sv;
        state_nxt = S_NBR;
      end

      // neighbor distance pass
      S_NBR: begin
        if (dv_r) begin
          if (jd_r != pending_r) begin
            any_nxt = 1'b1;
            if (is_near) begin
              near_nxt = 1'b1;
            end else if (diff > 0) begin
              down_nxt = 1'b1;
            end else begin
              up_nxt = 1'b1;
            end
          end
          if (jd_r == hi_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        if (is_outlier) begin
          rlo_nxt   = (win_n - CW'(1)) >> 1;
          rhi_nxt   = win_n >> 1;
          cand_nxt  = lo_r;
          state_nxt = S_CAND;
        end else begin
          res_nxt   = x_r;
          repl_nxt  = 1'b0;
          state_nxt = S_EMIT;
        end
      end

      // median by rank: fetch one candidate, count entries below it
      S_CAND: begin
        rd_en     = 1'b1;
        rd_idx    = cand_r;
        state_nxt = S_CANDW;
      end

      S_CANDW: begin
        cv_nxt     = sv;
        lt_nxt     = '0;
        le_nxt     = '0;
        scan_j_nxt = lo_r;
        iss_nxt    = 1'b1;
        dv_nxt     = 1'b0;
        state_nxt  = S_INNER;
      end

      S_INNER: begin
        if (dv_r) begin
          if (sv < cv_r) begin
            lt_nxt = lt_r + CW'(1);
          end
          if (sv <= cv_r) begin
            le_nxt = le_r + CW'(1);
          end
          if (jd_r == hi_r) begin
            state_nxt = S_RANK;
          end
        end
      end

      // candidate covers sorted positions lt .. le-1
      S_RANK: begin
        if ((lt_r <= rlo_r) && (rlo_r < le_r)) begin
          tlo_nxt = cv_r;
        end
        if ((lt_r <= rhi_r) && (rhi_r < le_r)) begin
          thi_nxt = cv_r;
        end
        if (cand_r == hi_r) begin
          state_nxt = S_MEDFIN;
        end else begin
          cand_nxt  = cand_r + CW'(1);
          state_nxt = S_CAND;
        end
      end

      // median +/- offset, saturated
      S_MEDFIN: begin
        res_nxt   = clamped[SB-1:0];
        repl_nxt  = 1'b1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.smoothed    = res_r;
          out_data_nxt.was_outlier = repl_r;
          out_data_nxt.run_last    = (pending_r == e_r);
          pending_nxt              = pending_r + CW'(1);
          state_nxt                = (pending_r == e_r) ? S_FINISH : S_CENTER;
        end
      end

      // end of segment resets the window; otherwise trim old left context
      S_FINISH: begin
        if (last_r) begin
          base_nxt    = '0;
          filled_nxt  = '0;
          pending_nxt = '0;
        end else if (pending_r > k_r) begin
          base_nxt    = wrap_idx(base_r, pending_r - k_r);
          filled_nxt  = filled_r - (pending_r - k_r);
          pending_nxt = k_r;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_half_window_r <= oms_pkg::HALF_WINDOW_RST;
      cfg_threshold_r   <= oms_pkg::THRESHOLD_RST;
      cfg_pull_offset_r <= oms_pkg::PULL_OFFSET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        oms_pkg::REG_HALF_WINDOW: cfg_half_window_r <= cfg_wdata[4:0];
        oms_pkg::REG_THRESHOLD:   cfg_threshold_r   <= cfg_wdata[14:0];
        oms_pkg::REG_PULL_OFFSET: cfg_pull_offset_r <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      filled_r    <= '0;
      pending_r   <= '0;
      k_r         <= '0;
      e_r         <= '0;
      last_r      <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      scan_j_r    <= '0;
      iss_r       <= 1'b0;
      dv_r        <= 1'b0;
      jd_r        <= '0;
      any_r       <= 1'b0;
      near_r      <= 1'b0;
      up_r        <= 1'b0;
      down_r      <= 1'b0;
      cand_r      <= '0;
      lt_r        <= '0;
      le_r        <= '0;
      rlo_r       <= '0;
      rhi_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      filled_r    <= filled_nxt;
      pending_r   <= pending_nxt;
      k_r         <= k_nxt;
      e_r         <= e_nxt;
      last_r      <= last_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      scan_j_r    <= scan_j_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      jd_r        <= jd_nxt;
      any_r       <= any_nxt;
      near_r      <= near_nxt;
      up_r        <= up_nxt;
      down_r      <= down_nxt;
      cand_r      <= cand_nxt;
      lt_r        <= lt_nxt;
      le_r        <= le_nxt;
      rlo_r       <= rlo_nxt;
      rhi_r       <= rhi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    cv_r       <= cv_nxt;
    tlo_r      <= tlo_nxt;
    thi_r      <= thi_nxt;
    res_r      <= res_nxt;
    repl_r     <= repl_nxt;
    out_data_r <= out_data_nxt;
  end

  // window bookkeeping stays consistent
  assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= filled_r)
    else $error("pending center beyond filled entries");

  assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CW'(DEPTH))
    else $error("window store overfilled");

  // between requests no more than k samples of left context wait
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pending_r <= k_r))
    else $error("left context not trimmed");

  // segment end empties the window
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FINISH) && last_r) |=> (filled_r == '0) && (pending_r == '0))
    else $error("segment end did not flush the window");

  // the two middle ranks come out ordered
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEDFIN) |-> (tlo_r <= thi_r))
    else $error("median middle values out of order");

endmodule

>>> rtl/oms_ram.sv
// ----------------------------------------------------------------------------
// oms_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module oms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
